// ===== sv/mjm_pkg.sv =====
// Shared widths, register defaults, register indexes and types of the mecanum mixer.
`timescale 1ns / 1ps

package mjm_pkg;

    localparam int STICK_W    = 8;
    localparam int AXIS_W     = 9;
    localparam int SCALED_W   = 17;
    localparam int MIX_W      = 18;
    localparam int MAG_W      = 16;
    localparam int NUM_W      = 25;
    localparam int QUO_W      = 9;
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEP   = 3;
    localparam int PWM_W      = 8;
    localparam int DZ_W       = 7;
    localparam int GAIN_W     = 8;
    localparam int LIMIT_W    = 8;
    localparam int CAL_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int NUM_STAGES = 9;

    localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 7'd10;
    localparam logic [GAIN_W-1:0]  AXIS_GAIN_RST = 8'd16;
    localparam logic [LIMIT_W-1:0] MIX_LIMIT_RST = 8'd100;
    localparam logic [CAL_W-1:0]   CAL_RST       = 9'd256;

    localparam logic [PWM_W-1:0] PWM_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE       = 3'd0,
        REG_AXIS_GAIN       = 3'd1,
        REG_MIX_LIMIT       = 3'd2,
        REG_CAL_FRONT_LEFT  = 3'd3,
        REG_CAL_FRONT_RIGHT = 3'd4,
        REG_CAL_REAR_LEFT   = 3'd5,
        REG_CAL_REAR_RIGHT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic             rescale;
        logic             peak_is_plus;
        logic             dir_plus;
        logic             dir_minus;
        logic             stop;
        logic [PWM_W-1:0] duty_plus;
        logic [PWM_W-1:0] duty_minus;
    } t_side;

endpackage

// ===== sv/mjm_div.sv =====
// Three-stage restoring divider that yields the rescaled duty quotient.
`timescale 1ns / 1ps

module mjm_div (
    input  logic                        i_clk,
    input  logic [mjm_pkg::DIV_STAGES-1:0] i_en,
    input  logic [mjm_pkg::NUM_W-1:0]   i_num,
    input  logic [mjm_pkg::MAG_W-1:0]   i_den,
    output logic [mjm_pkg::QUO_W-1:0]   o_quo
);

    localparam int BIT_W = $clog2(mjm_pkg::QUO_W);

    logic [mjm_pkg::NUM_W-1:0] r_rem [mjm_pkg::DIV_STAGES];
    logic [mjm_pkg::MAG_W-1:0] r_den [mjm_pkg::DIV_STAGES];
    logic [mjm_pkg::QUO_W-1:0] r_quo [mjm_pkg::DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < mjm_pkg::DIV_STAGES; k++) begin : g_stage
            localparam int PREV = (k == 0) ? 0 : k - 1;

            logic [mjm_pkg::NUM_W-1:0] n_rem;
            logic [mjm_pkg::QUO_W-1:0] n_quo;
            logic [mjm_pkg::MAG_W-1:0] den_in;

            always_comb begin
                logic [mjm_pkg::NUM_W-1:0] dsh;
                logic [BIT_W-1:0]          b;
                if (k == 0) begin
                    n_rem  = i_num;
                    n_quo  = '0;
                    den_in = i_den;
                end else begin
                    n_rem  = r_rem[PREV];
                    n_quo  = r_quo[PREV];
                    den_in = r_den[PREV];
                end
                for (int j = 0; j < mjm_pkg::DIV_STEP; j++) begin
                    b   = BIT_W'(mjm_pkg::QUO_W - 1 - (k * mjm_pkg::DIV_STEP + j));
                    dsh = {{(mjm_pkg::NUM_W-mjm_pkg::MAG_W){1'b0}}, den_in} << b;
                    if (n_rem >= dsh) begin
                        n_rem    = n_rem - dsh;
                        n_quo[b] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= n_rem;
                    r_quo[k] <= n_quo;
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[mjm_pkg::DIV_STAGES-1];

endmodule

// ===== sv/mecanum_joystick_mixer_core.sv =====
// Top level of the mecanum joystick mixer: deadzone, gain, mixing, rescale and calibration.
`timescale 1ns / 1ps

// One stick sample enters per cycle unless the input is stalled; its four wheel commands
// leave after the nine register stages that set the depth, three of which form the divider
// that rescales the mix to the limit. Stalls fill empty stages before the input is held.
// The user must write configuration registers only while the block is idle; the block
// itself does not enforce this.
module mecanum_joystick_mixer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mjm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mjm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mjm_pkg::STICK_W-1:0]  i_stick_x,
    input  logic signed [mjm_pkg::STICK_W-1:0]  i_stick_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mjm_pkg::PWM_W-1:0]           o_pwm_front_left,
    output logic [mjm_pkg::PWM_W-1:0]           o_pwm_front_right,
    output logic [mjm_pkg::PWM_W-1:0]           o_pwm_rear_left,
    output logic [mjm_pkg::PWM_W-1:0]           o_pwm_rear_right,
    output logic                                o_dir_front_left,
    output logic                                o_dir_front_right,
    output logic                                o_dir_rear_left,
    output logic                                o_dir_rear_right,
    output logic                                o_stopped
);

    logic [mjm_pkg::DZ_W-1:0]    r_dead_zone;
    logic [mjm_pkg::GAIN_W-1:0]  r_axis_gain;
    logic [mjm_pkg::LIMIT_W-1:0] r_mix_limit;
    logic [mjm_pkg::CAL_W-1:0]   r_cal_fl;
    logic [mjm_pkg::CAL_W-1:0]   r_cal_fr;
    logic [mjm_pkg::CAL_W-1:0]   r_cal_rl;
    logic [mjm_pkg::CAL_W-1:0]   r_cal_rr;

    logic [mjm_pkg::NUM_STAGES-1:0] r_vld;
    logic [mjm_pkg::NUM_STAGES-1:0] en;

    logic signed [mjm_pkg::AXIS_W-1:0]   r_s0_gx;
    logic signed [mjm_pkg::AXIS_W-1:0]   r_s0_gy;
    logic                                r_s0_stop;
    logic signed [mjm_pkg::SCALED_W-1:0] r_s1_sx;
    logic signed [mjm_pkg::SCALED_W-1:0] r_s1_sy;
    logic                                r_s1_stop;
    logic [mjm_pkg::MAG_W-1:0]           r_s2_small;
    logic [mjm_pkg::MAG_W-1:0]           r_s2_peak;
    logic [mjm_pkg::NUM_W-1:0]           r_s3_num;
    logic [mjm_pkg::MAG_W-1:0]           r_s3_peak;
    mjm_pkg::t_side                      r_side [2:6];
    logic [mjm_pkg::PWM_W-1:0]           r_s7_dp;
    logic [mjm_pkg::PWM_W-1:0]           r_s7_dm;
    logic                                r_s7_dirp;
    logic                                r_s7_dirm;
    logic                                r_s7_stop;
    logic [mjm_pkg::PWM_W-1:0]           r_pwm_fl;
    logic [mjm_pkg::PWM_W-1:0]           r_pwm_fr;
    logic [mjm_pkg::PWM_W-1:0]           r_pwm_rl;
    logic [mjm_pkg::PWM_W-1:0]           r_pwm_rr;
    logic                                r_dirp;
    logic                                r_dirm;
    logic                                r_stop;

    logic [mjm_pkg::QUO_W-1:0] quo;

    // Stage enables: a stage may load when it is empty or its successor moves on.
    always_comb begin
        en[mjm_pkg::NUM_STAGES-1] = !r_vld[mjm_pkg::NUM_STAGES-1] || !i_out_stall;
        for (int k = mjm_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= mjm_pkg::DEAD_ZONE_RST;
            r_axis_gain <= mjm_pkg::AXIS_GAIN_RST;
            r_mix_limit <= mjm_pkg::MIX_LIMIT_RST;
            r_cal_fl    <= mjm_pkg::CAL_RST;
            r_cal_fr    <= mjm_pkg::CAL_RST;
            r_cal_rl    <= mjm_pkg::CAL_RST;
            r_cal_rr    <= mjm_pkg::CAL_RST;
            r_vld       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (mjm_pkg::t_reg_idx'(i_cfg_idx))
                    mjm_pkg::REG_DEAD_ZONE:       r_dead_zone <= i_cfg_data[mjm_pkg::DZ_W-1:0];
                    mjm_pkg::REG_AXIS_GAIN:       r_axis_gain <= i_cfg_data[mjm_pkg::GAIN_W-1:0];
                    mjm_pkg::REG_MIX_LIMIT:       r_mix_limit <= i_cfg_data[mjm_pkg::LIMIT_W-1:0];
                    mjm_pkg::REG_CAL_FRONT_LEFT:  r_cal_fl    <= i_cfg_data[mjm_pkg::CAL_W-1:0];
                    mjm_pkg::REG_CAL_FRONT_RIGHT: r_cal_fr    <= i_cfg_data[mjm_pkg::CAL_W-1:0];
                    mjm_pkg::REG_CAL_REAR_LEFT:   r_cal_rl    <= i_cfg_data[mjm_pkg::CAL_W-1:0];
                    mjm_pkg::REG_CAL_REAR_RIGHT:  r_cal_rr    <= i_cfg_data[mjm_pkg::CAL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < mjm_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: negate x and apply the deadzone.
    logic signed [mjm_pkg::AXIS_W-1:0] nx;
    logic signed [mjm_pkg::AXIS_W-1:0] ey;
    logic [mjm_pkg::AXIS_W-1:0]        ax;
    logic [mjm_pkg::AXIS_W-1:0]        ay;
    logic                              x_dead;
    logic                              y_dead;

    always_comb begin
        nx     = -{i_stick_x[mjm_pkg::STICK_W-1], i_stick_x};
        ey     = {i_stick_y[mjm_pkg::STICK_W-1], i_stick_y};
        ax     = nx[mjm_pkg::AXIS_W-1] ? 9'(-nx) : 9'(nx);
        ay     = ey[mjm_pkg::AXIS_W-1] ? 9'(-ey) : 9'(ey);
        x_dead = ax <= {2'b00, r_dead_zone};
        y_dead = ay <= {2'b00, r_dead_zone};
    end

    // Stage 1: axis gain.
    logic signed [mjm_pkg::MIX_W-1:0] px;
    logic signed [mjm_pkg::MIX_W-1:0] py;

    always_comb begin
        px = r_s0_gx * $signed({1'b0, r_axis_gain});
        py = r_s0_gy * $signed({1'b0, r_axis_gain});
    end

    // Stage 2: mixing, magnitudes, peak and the unscaled duties.
    logic signed [mjm_pkg::MIX_W-1:0] plus;
    logic signed [mjm_pkg::MIX_W-1:0] minus;
    logic [mjm_pkg::MAG_W-1:0]        mp;
    logic [mjm_pkg::MAG_W-1:0]        mm;
    mjm_pkg::t_side                   n_side;
    logic [mjm_pkg::MAG_W-1:0]        n_small;
    logic [mjm_pkg::MAG_W-1:0]        n_peak;

    always_comb begin
        plus  = {r_s1_sy[mjm_pkg::SCALED_W-1], r_s1_sy} + {r_s1_sx[mjm_pkg::SCALED_W-1], r_s1_sx};
        minus = {r_s1_sy[mjm_pkg::SCALED_W-1], r_s1_sy} - {r_s1_sx[mjm_pkg::SCALED_W-1], r_s1_sx};
        mp    = plus[mjm_pkg::MIX_W-1]  ? 16'(-plus)  : plus[mjm_pkg::MAG_W-1:0];
        mm    = minus[mjm_pkg::MIX_W-1] ? 16'(-minus) : minus[mjm_pkg::MAG_W-1:0];
        n_side.peak_is_plus = mp >= mm;
        n_peak  = n_side.peak_is_plus ? mp : mm;
        n_small = n_side.peak_is_plus ? mm : mp;
        n_side.rescale    = n_peak > {4'b0000, r_mix_limit, 4'b0000};
        n_side.dir_plus   = !plus[mjm_pkg::MIX_W-1];
        n_side.dir_minus  = !minus[mjm_pkg::MIX_W-1];
        n_side.stop       = r_s1_stop;
        n_side.duty_plus  = (|mp[15:11]) ? mjm_pkg::PWM_MAX : mp[10:3];
        n_side.duty_minus = (|mm[15:11]) ? mjm_pkg::PWM_MAX : mm[10:3];
    end

    // Stage 3: dividend of the rescale, smaller magnitude times twice the limit.
    logic [mjm_pkg::NUM_W-2:0] num_prod;

    assign num_prod = r_s2_small * r_mix_limit;

    mjm_div u_div (
        .i_clk (i_clk),
        .i_en  (en[6:4]),
        .i_num (r_s3_num),
        .i_den (r_s3_peak),
        .o_quo (quo)
    );

    // Stage 7: choose between the plain and the rescaled duty.
    logic [mjm_pkg::LIMIT_W:0] lim2;
    logic [mjm_pkg::PWM_W-1:0] lim2_sat;
    logic [mjm_pkg::PWM_W-1:0] quo_sat;
    logic [mjm_pkg::PWM_W-1:0] n_dp;
    logic [mjm_pkg::PWM_W-1:0] n_dm;

    always_comb begin
        lim2     = {r_mix_limit, 1'b0};
        lim2_sat = lim2[mjm_pkg::LIMIT_W] ? mjm_pkg::PWM_MAX : lim2[mjm_pkg::PWM_W-1:0];
        quo_sat  = quo[mjm_pkg::QUO_W-1] ? mjm_pkg::PWM_MAX : quo[mjm_pkg::PWM_W-1:0];
        if (r_side[6].rescale) begin
            n_dp = r_side[6].peak_is_plus ? lim2_sat : quo_sat;
            n_dm = r_side[6].peak_is_plus ? quo_sat : lim2_sat;
        end else begin
            n_dp = r_side[6].duty_plus;
            n_dm = r_side[6].duty_minus;
        end
    end

    // Stage 8: per-wheel calibration.
    function automatic logic [mjm_pkg::PWM_W-1:0] calibrate(
        input logic [mjm_pkg::PWM_W-1:0] duty,
        input logic [mjm_pkg::CAL_W-1:0] ratio
    );
        logic [mjm_pkg::PWM_W+mjm_pkg::CAL_W-1:0] prod;
        prod = duty * ratio;
        return prod[16] ? mjm_pkg::PWM_MAX : prod[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_gx   <= x_dead ? '0 : nx;
            r_s0_gy   <= y_dead ? '0 : ey;
            r_s0_stop <= x_dead && y_dead;
        end
        if (en[1]) begin
            r_s1_sx   <= px[mjm_pkg::SCALED_W-1:0];
            r_s1_sy   <= py[mjm_pkg::SCALED_W-1:0];
            r_s1_stop <= r_s0_stop;
        end
        if (en[2]) begin
            r_side[2]  <= n_side;
            r_s2_small <= n_small;
            r_s2_peak  <= n_peak;
        end
        if (en[3]) begin
            r_s3_num  <= {num_prod, 1'b0};
            r_s3_peak <= r_s2_peak;
        end
        for (int k = 3; k <= 6; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (en[7]) begin
            r_s7_dp   <= n_dp;
            r_s7_dm   <= n_dm;
            r_s7_dirp <= r_side[6].dir_plus;
            r_s7_dirm <= r_side[6].dir_minus;
            r_s7_stop <= r_side[6].stop;
        end
        if (en[8]) begin
            r_pwm_fl <= calibrate(r_s7_dp, r_cal_fl);
            r_pwm_fr <= calibrate(r_s7_dm, r_cal_fr);
            r_pwm_rl <= calibrate(r_s7_dm, r_cal_rl);
            r_pwm_rr <= calibrate(r_s7_dp, r_cal_rr);
            r_dirp   <= r_s7_dirp;
            r_dirm   <= r_s7_dirm;
            r_stop   <= r_s7_stop;
        end
    end

    assign o_out_valid       = r_vld[mjm_pkg::NUM_STAGES-1];
    assign o_pwm_front_left  = r_pwm_fl;
    assign o_pwm_front_right = r_pwm_fr;
    assign o_pwm_rear_left   = r_pwm_rl;
    assign o_pwm_rear_right  = r_pwm_rr;
    assign o_dir_front_left  = r_dirp;
    assign o_dir_front_right = r_dirm;
    assign o_dir_rear_left   = r_dirm;
    assign o_dir_rear_right  = r_dirp;
    assign o_stopped         = r_stop;

endmodule

// ===== sv/mjm_checker.sv =====
// Port-level assertions for the mecanum mixer and the bind that attaches them.
`timescale 1ns / 1ps

module mjm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [mjm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input logic [mjm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic signed [mjm_pkg::STICK_W-1:0]  i_stick_x,
    input logic signed [mjm_pkg::STICK_W-1:0]  i_stick_y,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [mjm_pkg::PWM_W-1:0]           o_pwm_front_left,
    input logic [mjm_pkg::PWM_W-1:0]           o_pwm_front_right,
    input logic [mjm_pkg::PWM_W-1:0]           o_pwm_rear_left,
    input logic [mjm_pkg::PWM_W-1:0]           o_pwm_rear_right,
    input logic                                o_dir_front_left,
    input logic                                o_dir_front_right,
    input logic                                o_dir_rear_left,
    input logic                                o_dir_rear_right,
    input logic                                o_stopped
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pwm_front_left)
            && $stable(o_pwm_front_right) && $stable(o_pwm_rear_left)
            && $stable(o_pwm_rear_right) && $stable(o_stopped))
        else $error("stalled output beat changed");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the pipeline drains");

    a_stop_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stopped |-> o_pwm_front_left == '0 && o_pwm_front_right == '0
            && o_pwm_rear_left == '0 && o_pwm_rear_right == '0
            && o_dir_front_left && o_dir_front_right && o_dir_rear_left && o_dir_rear_right)
        else $error("stop beat carries drive");

    a_diag_dirs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_dir_front_left == o_dir_rear_right
            && o_dir_front_right == o_dir_rear_left)
        else $error("diagonal wheel directions disagree");

endmodule

bind mecanum_joystick_mixer_core mjm_checker u_mjm_checker (.*);

// ===== tb/mecanum_joystick_mixer_core_test.sv =====
// Self-checking testbench of the mecanum joystick mixer: directed and random stick beats.
`timescale 1ns / 1ps

module mecanum_joystick_mixer_core_test;
    import mjm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [3:0][PWM_W-1:0] pwm;
        logic [3:0]            dir;
        logic                  stopped;
    } wheel_cmd_t;

    class wheel_cmd_checker;
        int unsigned dz;
        int unsigned gain;
        int unsigned limit;
        int unsigned cal[4];
        wheel_cmd_t  pending_cmds[$];
        int          mismatches;
        string       wheel_names[4];

        function new();
            dz = DEAD_ZONE_RST;
            gain = AXIS_GAIN_RST;
            limit = MIX_LIMIT_RST;
            foreach (cal[i]) cal[i] = CAL_RST;
            mismatches = 0;
            wheel_names = '{"front_left", "front_right", "rear_left", "rear_right"};
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEAD_ZONE:       dz = data[DZ_W-1:0];
                REG_AXIS_GAIN:       gain = data[GAIN_W-1:0];
                REG_MIX_LIMIT:       limit = data[LIMIT_W-1:0];
                REG_CAL_FRONT_LEFT:  cal[0] = data;
                REG_CAL_FRONT_RIGHT: cal[1] = data;
                REG_CAL_REAR_LEFT:   cal[2] = data;
                REG_CAL_REAR_RIGHT:  cal[3] = data;
                default: ;
            endcase
        endfunction

        function int dz_gate(int a);
            int unsigned m;
            m = (a < 0) ? -a : a;
            return (m <= dz) ? 0 : a;
        endfunction

        function logic [PWM_W-1:0] wheel_duty(int unsigned mag, int unsigned peak,
                                              bit rescale, int unsigned ratio);
            int unsigned d;
            d = rescale ? (mag * limit * 2) / peak : (mag * 2) >> 4;
            if (d > 255) d = 255;
            d = (d * ratio) >> 8;
            if (d > 255) d = 255;
            return d[PWM_W-1:0];
        endfunction

        function wheel_cmd_t predict_wheels(logic signed [STICK_W-1:0] sx,
                                            logic signed [STICK_W-1:0] sy);
            int          ax, ay, plus_v, minus_v;
            int unsigned mp, mm, peak;
            bit          rescale;
            wheel_cmd_t  c;
            ax = dz_gate(-int'(sx));
            ay = dz_gate(int'(sy));
            if (ax == 0 && ay == 0) begin
                c.pwm = '0;
                c.dir = '1;
                c.stopped = 1'b1;
                return c;
            end
            plus_v = ay * int'(gain) + ax * int'(gain);
            minus_v = ay * int'(gain) - ax * int'(gain);
            mp = (plus_v < 0) ? -plus_v : plus_v;
            mm = (minus_v < 0) ? -minus_v : minus_v;
            peak = (mp > mm) ? mp : mm;
            rescale = peak > limit * 16;
            c.pwm[0] = wheel_duty(mp, peak, rescale, cal[0]);
            c.pwm[1] = wheel_duty(mm, peak, rescale, cal[1]);
            c.pwm[2] = wheel_duty(mm, peak, rescale, cal[2]);
            c.pwm[3] = wheel_duty(mp, peak, rescale, cal[3]);
            c.dir[0] = plus_v >= 0;
            c.dir[1] = minus_v >= 0;
            c.dir[2] = minus_v >= 0;
            c.dir[3] = plus_v >= 0;
            c.stopped = 1'b0;
            return c;
        endfunction

        function void note_input(logic signed [STICK_W-1:0] sx, logic signed [STICK_W-1:0] sy);
            pending_cmds.push_back(predict_wheels(sx, sy));
        endfunction

        function void check_result(wheel_cmd_t act);
            wheel_cmd_t exp_cmd;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p", $time, act);
                mismatches++;
                return;
            end
            exp_cmd = pending_cmds.pop_front();
            for (int w = 0; w < 4; w++) begin
                if (act.pwm[w] !== exp_cmd.pwm[w]) begin
                    $display("%0t: pwm_%s expected %0d actual %0d", $time, wheel_names[w],
                             exp_cmd.pwm[w], act.pwm[w]);
                    mismatches++;
                end
                if (act.dir[w] !== exp_cmd.dir[w]) begin
                    $display("%0t: dir_%s expected %0d actual %0d", $time, wheel_names[w],
                             exp_cmd.dir[w], act.dir[w]);
                    mismatches++;
                end
            end
            if (act.stopped !== exp_cmd.stopped) begin
                $display("%0t: stopped expected %0d actual %0d", $time, exp_cmd.stopped,
                         act.stopped);
                mismatches++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [STICK_W-1:0]   i_stick_x = '0;
    logic signed [STICK_W-1:0]   i_stick_y = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [PWM_W-1:0]            o_pwm_front_left;
    logic [PWM_W-1:0]            o_pwm_front_right;
    logic [PWM_W-1:0]            o_pwm_rear_left;
    logic [PWM_W-1:0]            o_pwm_rear_right;
    logic                        o_dir_front_left;
    logic                        o_dir_front_right;
    logic                        o_dir_rear_left;
    logic                        o_dir_rear_right;
    logic                        o_stopped;

    wheel_cmd_checker sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    logic signed [STICK_W-1:0] directed_x[N_DIRECTED] = '{
        0, 10, 11, 0, -11, 0, 100, -100, 100, -100, -128, 127,
        -128, 127, 0, 100, 0, -100, 50, -37, 1, -1, 85};
    logic signed [STICK_W-1:0] directed_y[N_DIRECTED] = '{
        0, -10, 0, 11, 0, -11, 100, -100, -100, 100, -128, 127,
        127, -128, 100, 0, -100, 0, 20, 64, -1, 1, -3};

    mecanum_joystick_mixer_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_stick_x         (i_stick_x),
        .i_stick_y         (i_stick_y),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pwm_front_left  (o_pwm_front_left),
        .o_pwm_front_right (o_pwm_front_right),
        .o_pwm_rear_left   (o_pwm_rear_left),
        .o_pwm_rear_right  (o_pwm_rear_right),
        .o_dir_front_left  (o_dir_front_left),
        .o_dir_front_right (o_dir_front_right),
        .o_dir_rear_left   (o_dir_rear_left),
        .o_dir_rear_right  (o_dir_rear_right),
        .o_stopped         (o_stopped)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left = mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            2: i_out_stall <= (mode_left % 3 == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        wheel_cmd_t act;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act.pwm = {o_pwm_rear_right, o_pwm_rear_left, o_pwm_front_right, o_pwm_front_left};
            act.dir = {o_dir_rear_right, o_dir_rear_left, o_dir_front_right, o_dir_front_left};
            act.stopped = o_stopped;
            sb.check_result(act);
        end
    end

    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_stick(logic signed [STICK_W-1:0] sx, logic signed [STICK_W-1:0] sy);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_stick_x <= sx;
        i_stick_y <= sy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(sx, sy);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(int dz, int gain, int limit, int fl, int fr, int rl, int rr);
        write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz));
        write_reg(REG_AXIS_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_MIX_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_CAL_FRONT_LEFT, CFG_DATA_W'(fl));
        write_reg(REG_CAL_FRONT_RIGHT, CFG_DATA_W'(fr));
        write_reg(REG_CAL_REAR_LEFT, CFG_DATA_W'(rl));
        write_reg(REG_CAL_REAR_RIGHT, CFG_DATA_W'(rr));
    endtask

    function automatic logic signed [STICK_W-1:0] pick_axis();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, 200) - 100;
            6: v = $urandom_range(0, 255);
            7: v = (int'(sb.dz) + $urandom_range(0, 4) - 2) * ($urandom_range(0, 1) ? 1 : -1);
            8: v = 0;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = -128;
                    1: v = 127;
                    2: v = -100;
                    default: v = 100;
                endcase
            end
        endcase
        return v[STICK_W-1:0];
    endfunction

    task automatic send_random(int count);
        repeat (count) send_stick(pick_axis(), pick_axis());
    endtask

    function automatic int raw_or(int in_range);
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511)) : in_range;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) send_stick(directed_x[k], directed_y[k]);
        send_random(100);

        wait_drained();
        write_all(0, 255, 255, 511, 511, 511, 511);
        send_random(130);

        wait_drained();
        write_all(100, 16, 1, 0, 256, 511, 128);
        send_random(100);

        wait_drained();
        write_all(10, 0, 100, 256, 256, 256, 256);
        send_random(60);

        wait_drained();
        write_all(5, 32, 0, 300, 200, 100, 511);
        send_random(80);

        wait_drained();
        write_all(9'h1FF, 9'h110, 9'h150, 256, 256, 256, 256);
        write_reg(REG_NONE, 9'h000);
        write_reg(REG_NONE, 9'h1FF);
        send_random(60);

        repeat (8) begin
            wait_drained();
            write_all(raw_or($urandom_range(0, 100)), raw_or($urandom_range(0, 255)),
                      raw_or(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255)),
                      $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 511), $urandom_range(0, 511));
            send_random(125);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
